### hdl/assert_macros.svh
// assertion macros shared by the frame header parser rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSFHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WSFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wsfhp_pkg.sv
// types, constants and helpers for the websocket frame header parser
// no dependencies; used by wsfhp_parser, the top level, the header checker and the testbench
package wsfhp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned POS_W  = 4;

    // length codes in the second header byte
    localparam logic [6:0] CODE_EXT16 = 7'd126;
    localparam logic [6:0] CODE_EXT64 = 7'd127;

    // header size pieces in bytes
    localparam logic [POS_W-1:0] HDR_BASE_BYTES  = 4'd2;
    localparam logic [POS_W-1:0] EXT16_BYTES     = 4'd2;
    localparam logic [POS_W-1:0] EXT64_BYTES     = 4'd8;
    localparam logic [POS_W-1:0] KEY_BYTES       = 4'd4;

    // limit register value after reset
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'h0fff_ffff;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_EXT16 = 2'd1,
        LEN_EXT64 = 2'd2
    } len_form_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first;
    } in_beat_t;

    typedef struct packed {
        logic              fin;
        logic              rsv1;
        logic              rsv2;
        logic              rsv3;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic [LEN_W-1:0]  masking_key;
        logic [POS_W-1:0]  header_bytes;
        logic              status;
    } out_beat_t;

    // parser to output stage
    typedef struct packed {
        logic      done;
        out_beat_t data;
    } parse_res_t;

    // byte position just past the length field
    function automatic logic [POS_W-1:0] len_end(input len_form_t form);
        logic [POS_W-1:0] n;
        begin
            n = HDR_BASE_BYTES;
            case (form)
                LEN_EXT16: n = HDR_BASE_BYTES + EXT16_BYTES;
                LEN_EXT64: n = HDR_BASE_BYTES + EXT64_BYTES;
                default:   n = HDR_BASE_BYTES;
            endcase
            return n;
        end
    endfunction

    // full header length
    function automatic logic [POS_W-1:0] hdr_total(input len_form_t form, input logic mask);
        begin
            return len_end(form) + (mask ? KEY_BYTES : '0);
        end
    endfunction

endpackage

### hdl/wsfhp_parser.sv
// byte counter and field accumulators for the frame header parser
// depends on wsfhp_pkg and assert_macros.svh
`include "assert_macros.svh"

module wsfhp_parser (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   beat_fire,
    input  wsfhp_pkg::in_beat_t                    beat,
    input  logic [wsfhp_pkg::LEN_W-1:0]            max_len,
    output wsfhp_pkg::parse_res_t                  res
);

    logic [wsfhp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [wsfhp_pkg::BYTE_W-1:0] first_byte_reg, first_byte_next;
    logic                         mask_reg, mask_next;
    wsfhp_pkg::len_form_t         form_reg, form_next;
    logic [wsfhp_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [wsfhp_pkg::LEN_W-1:0]  key_reg, key_next;
    logic                         active_reg, active_next;
    logic [wsfhp_pkg::POS_W-1:0]  total;
    logic                         done;
    logic [6:0]                   code;

    assign code = beat.data_byte[6:0];

    // next state for one header byte
    always_comb
    begin
        pos_next        = pos_reg;
        first_byte_next = first_byte_reg;
        mask_next       = mask_reg;
        form_next       = form_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        active_next     = active_reg;
        total           = wsfhp_pkg::hdr_total(form_reg, mask_reg);
        done            = 1'b0;
        if (beat_fire)
        begin
            if (beat.first)
            begin
                // new frame always restarts the header
                first_byte_next = beat.data_byte;
                pos_next        = 4'd1;
                mask_next       = 1'b0;
                form_next       = wsfhp_pkg::LEN_SHORT;
                len_next        = '0;
                key_next        = '0;
                active_next     = 1'b1;
            end
            else if (active_reg)
            begin
                if (pos_reg == 4'd1)
                begin
                    // mask bit and length code
                    mask_next = beat.data_byte[7];
                    if (code == wsfhp_pkg::CODE_EXT16)
                    begin
                        form_next = wsfhp_pkg::LEN_EXT16;
                        len_next  = '0;
                    end
                    else if (code == wsfhp_pkg::CODE_EXT64)
                    begin
                        form_next = wsfhp_pkg::LEN_EXT64;
                        len_next  = '0;
                    end
                    else
                    begin
                        form_next = wsfhp_pkg::LEN_SHORT;
                        len_next  = {{(wsfhp_pkg::LEN_W-7){1'b0}}, code};
                    end
                end
                else if (pos_reg < wsfhp_pkg::len_end(form_reg))
                begin
                    // extended length, big endian, upper bytes fall off
                    len_next = {len_reg[wsfhp_pkg::LEN_W-wsfhp_pkg::BYTE_W-1:0], beat.data_byte};
                end
                else
                begin
                    key_next = {key_reg[wsfhp_pkg::LEN_W-wsfhp_pkg::BYTE_W-1:0], beat.data_byte};
                end
                total = wsfhp_pkg::hdr_total(form_next, mask_next);
                if ((pos_reg + 4'd1) < total)
                begin
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    active_next = 1'b0;
                    pos_next    = '0;
                    done        = 1'b1;
                end
            end
        end
    end

    // result fields for a completed header
    always_comb
    begin
        res.done                = done;
        res.data.fin            = first_byte_reg[7];
        res.data.rsv1           = first_byte_reg[6];
        res.data.rsv2           = first_byte_reg[5];
        res.data.rsv3           = first_byte_reg[4];
        res.data.opcode         = first_byte_reg[3:0];
        res.data.masked         = mask_next;
        res.data.payload_length = len_next;
        res.data.masking_key    = mask_next ? key_next : '0;
        res.data.header_bytes   = total;
        res.data.status         = (len_next > max_len);
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            first_byte_reg <= '0;
            mask_reg       <= 1'b0;
            form_reg       <= wsfhp_pkg::LEN_SHORT;
            len_reg        <= '0;
            key_reg        <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            first_byte_reg <= first_byte_next;
            mask_reg       <= mask_next;
            form_reg       <= form_next;
            len_reg        <= len_next;
            key_reg        <= key_next;
            active_reg     <= active_next;
        end
    end

    // counter stays consistent with the open flag
    `WSFHP_ASSERT_IMPL(a_idle_pos_zero, clk, rst_n, !active_reg, pos_reg == '0, "idle parser with nonzero byte position")
    `WSFHP_ASSERT_IMPL(a_active_pos_range, clk, rst_n, active_reg, (pos_reg != '0) && (pos_reg < 4'd14), "open header with byte position out of range")

endmodule

### hdl/websocket_frame_header_parser_core.sv
// websocket frame header parser, top level with result register and skid entry
// depends on wsfhp_pkg, wsfhp_parser and assert_macros.svh
//
// Header bytes enter one per cycle on the input channel; a beat with first set
// opens a new header and drops any partial one. The decoded header comes out of
// a result register, loaded from the beat that completes it. Behind that
// register sits a single skid entry, so the input keeps taking one byte per cycle
// while a result waits; the input only stalls when a second finished result is
// held in the skid entry. Throughput is one byte per clock, set by the byte
// counter and shift registers in the parser. The payload length limit is written
// on the configuration channel, which is always ready; write it only while idle.
`include "assert_macros.svh"

module websocket_frame_header_parser_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  wsfhp_pkg::in_beat_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output wsfhp_pkg::out_beat_t           out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsfhp_pkg::LEN_W-1:0]    cfg_data
);

    logic [wsfhp_pkg::LEN_W-1:0] max_len_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        skid_valid_reg, skid_valid_next;
    wsfhp_pkg::out_beat_t        out_data_reg, out_data_next;
    wsfhp_pkg::out_beat_t        skid_data_reg, skid_data_next;
    wsfhp_pkg::parse_res_t       res;
    logic                        in_fire;
    logic                        res_fire;
    logic                        out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign res_fire  = res.done;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    wsfhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_fire (in_fire),
        .beat      (in_data),
        .max_len   (max_len_reg),
        .res       (res)
    );

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= wsfhp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    // result register and skid entry steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                out_data_next  = res.data;
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid entry only fills behind a held result, and a result is never dropped
    `WSFHP_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid entry holds data while result register is empty")
    `WSFHP_ASSERT_NEXT(a_stalled_result_kept, clk, rst_n, res_fire && out_valid_reg && !out_ready, skid_valid_reg && out_valid_reg, "finished header lost while output stalled")

endmodule

### dv/wsfhp_header_checker.sv
// header checker for the websocket frame header parser: predicts decoded headers
// from accepted input beats and compares them with the output channel
// depends on wsfhp_pkg for the beat types, length forms and size constants
module wsfhp_header_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  wsfhp_pkg::in_beat_t         in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  wsfhp_pkg::out_beat_t        out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [wsfhp_pkg::LEN_W-1:0] cfg_data,
    output int                          n_fail,
    output int                          n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the length limit register
    logic [wsfhp_pkg::LEN_W-1:0] max_len_q;

    // shadow of the header collection state
    logic [wsfhp_pkg::POS_W-1:0] hdr_pos_q;
    logic [7:0]                  hdr_b0_q;
    logic                        hdr_mask_q;
    wsfhp_pkg::len_form_t        hdr_form_q;
    logic [wsfhp_pkg::LEN_W-1:0] len_acc_q;
    logic [wsfhp_pkg::LEN_W-1:0] key_acc_q;
    logic                        hdr_open_q;

    wsfhp_pkg::out_beat_t        headers_due_q[$];
    int                          mism_cnt = 0;
    int                          due_cnt = 0;

    assign n_fail    = mism_cnt;
    assign n_pending = due_cnt;

    // one line per mismatch, counted
    task automatic report(input string msg);
        $display("[%0t] header mismatch: %s", $realtime, msg);
        mism_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // advance the header state by one accepted beat, queue a header when complete
    task automatic decode_beat(input wsfhp_pkg::in_beat_t beat);
        logic [wsfhp_pkg::POS_W-1:0] at;
        logic [wsfhp_pkg::POS_W-1:0] len_stop;
        logic [wsfhp_pkg::POS_W-1:0] total;
        logic [6:0]                  code;
        wsfhp_pkg::out_beat_t        hdr;
        if (beat.first)
        begin
            hdr_b0_q   = beat.data_byte;
            hdr_pos_q  = 4'd1;
            hdr_mask_q = 1'b0;
            hdr_form_q = wsfhp_pkg::LEN_SHORT;
            len_acc_q  = '0;
            key_acc_q  = '0;
            hdr_open_q = 1'b1;
        end
        else if (hdr_open_q)
        begin
            at = hdr_pos_q;
            // second byte: mask bit and length code
            if (at == 4'd1)
            begin
                code       = beat.data_byte[6:0];
                hdr_mask_q = beat.data_byte[7];
                if (code == wsfhp_pkg::CODE_EXT16)
                begin
                    hdr_form_q = wsfhp_pkg::LEN_EXT16;
                    len_acc_q  = '0;
                end
                else if (code == wsfhp_pkg::CODE_EXT64)
                begin
                    hdr_form_q = wsfhp_pkg::LEN_EXT64;
                    len_acc_q  = '0;
                end
                else
                begin
                    hdr_form_q = wsfhp_pkg::LEN_SHORT;
                    len_acc_q  = {25'd0, code};
                end
            end
            else
            begin
                // extended length bytes first, then key bytes, msb first
                len_stop = wsfhp_pkg::HDR_BASE_BYTES;
                if (hdr_form_q == wsfhp_pkg::LEN_EXT16)
                    len_stop = wsfhp_pkg::HDR_BASE_BYTES + wsfhp_pkg::EXT16_BYTES;
                else if (hdr_form_q == wsfhp_pkg::LEN_EXT64)
                    len_stop = wsfhp_pkg::HDR_BASE_BYTES + wsfhp_pkg::EXT64_BYTES;
                if (at < len_stop)
                    len_acc_q = {len_acc_q[23:0], beat.data_byte};
                else
                    key_acc_q = {key_acc_q[23:0], beat.data_byte};
            end

            total = wsfhp_pkg::HDR_BASE_BYTES;
            if (hdr_form_q == wsfhp_pkg::LEN_EXT16)
                total = total + wsfhp_pkg::EXT16_BYTES;
            else if (hdr_form_q == wsfhp_pkg::LEN_EXT64)
                total = total + wsfhp_pkg::EXT64_BYTES;
            if (hdr_mask_q)
                total = total + wsfhp_pkg::KEY_BYTES;
            hdr_pos_q = at + 4'd1;

            // header complete
            if (at + 4'd1 >= total)
            begin
                hdr_open_q         = 1'b0;
                hdr_pos_q          = '0;
                hdr.fin            = hdr_b0_q[7];
                hdr.rsv1           = hdr_b0_q[6];
                hdr.rsv2           = hdr_b0_q[5];
                hdr.rsv3           = hdr_b0_q[4];
                hdr.opcode         = hdr_b0_q[3:0];
                hdr.masked         = hdr_mask_q;
                hdr.payload_length = len_acc_q;
                hdr.masking_key    = hdr_mask_q ? key_acc_q : '0;
                hdr.header_bytes   = total;
                hdr.status         = (len_acc_q > max_len_q);
                headers_due_q.push_back(hdr);
            end
        end
    endtask

    // compare one output beat with the oldest predicted header
    task automatic check_header(input wsfhp_pkg::out_beat_t got);
        wsfhp_pkg::out_beat_t want;
        if (headers_due_q.size() == 0)
        begin
            report("output beat with no header predicted");
        end
        else
        begin
            want = headers_due_q.pop_front();
            cmp_field("fin", 32'(got.fin), 32'(want.fin));
            cmp_field("rsv1", 32'(got.rsv1), 32'(want.rsv1));
            cmp_field("rsv2", 32'(got.rsv2), 32'(want.rsv2));
            cmp_field("rsv3", 32'(got.rsv3), 32'(want.rsv3));
            cmp_field("opcode", 32'(got.opcode), 32'(want.opcode));
            cmp_field("masked", 32'(got.masked), 32'(want.masked));
            cmp_field("payload_length", got.payload_length, want.payload_length);
            cmp_field("masking_key", got.masking_key, want.masking_key);
            cmp_field("header_bytes", 32'(got.header_bytes), 32'(want.header_bytes));
            cmp_field("status", 32'(got.status), 32'(want.status));
        end
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_q  = wsfhp_pkg::MAX_LEN_RESET;
            hdr_pos_q  = '0;
            hdr_b0_q   = '0;
            hdr_mask_q = 1'b0;
            hdr_form_q = wsfhp_pkg::LEN_SHORT;
            len_acc_q  = '0;
            key_acc_q  = '0;
            hdr_open_q = 1'b0;
            headers_due_q.delete();
            due_cnt    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_q = cfg_data;
            if (out_valid && out_ready)
                check_header(out_data);
            if (in_valid && in_ready)
                decode_beat(in_data);
            due_cnt = headers_due_q.size();
        end
    end

endmodule

### dv/tb_websocket_frame_header_parser_core.sv
// testbench top for the websocket frame header parser: reset, clock, header
// stimulus with random idling, limit register writes, watchdog and verdict
// depends on wsfhp_pkg, the parser rtl and wsfhp_header_checker
module tb_websocket_frame_header_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int PHASES         = 7;
    localparam int BYTES_PER_PHASE = 230;
    localparam int SETTLE_CYCLES  = 4;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    wsfhp_pkg::in_beat_t         in_data;
    logic                        out_valid;
    logic                        out_ready;
    wsfhp_pkg::out_beat_t        out_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [wsfhp_pkg::LEN_W-1:0] cfg_data;

    int               n_fail;
    int               n_pending;
    int               stall_cycles = 0;

    // header bytes of the frame being sent
    logic [7:0]       hdr_q[$];
    int               sent_cnt = 0;
    bit               open_hdr = 1'b0;
    bit               in_idle_en = 1'b0;
    bit               quiet = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    websocket_frame_header_parser_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wsfhp_header_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    // one input beat, with an optional idle burst ahead of it
    task automatic push_byte(input logic [7:0] b, input logic f);
        if (in_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.data_byte <= b;
        in_data.first     <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // assemble a header: byte 0, length code, extended length, key
    task automatic build_header(input logic [7:0] b0, input logic mask,
                                input wsfhp_pkg::len_form_t form,
                                input logic [31:0] len, input logic [31:0] upper,
                                input logic [31:0] key);
        hdr_q.delete();
        hdr_q.push_back(b0);
        case (form)
            wsfhp_pkg::LEN_EXT16:
            begin
                hdr_q.push_back({mask, wsfhp_pkg::CODE_EXT16});
                hdr_q.push_back(len[15:8]);
                hdr_q.push_back(len[7:0]);
            end
            wsfhp_pkg::LEN_EXT64:
            begin
                hdr_q.push_back({mask, wsfhp_pkg::CODE_EXT64});
                for (int i = 3; i >= 0; i--)
                    hdr_q.push_back(upper[8*i +: 8]);
                for (int i = 3; i >= 0; i--)
                    hdr_q.push_back(len[8*i +: 8]);
            end
            default:
            begin
                hdr_q.push_back({mask, len[6:0]});
            end
        endcase
        if (mask)
        begin
            for (int i = 3; i >= 0; i--)
                hdr_q.push_back(key[8*i +: 8]);
        end
    endtask

    // send the first n bytes of the assembled header
    task automatic send_header(input int n);
        in_idle_en = !quiet && ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
            push_byte(hdr_q[i], i == 0);
        sent_cnt += n;
        open_hdr = (n < hdr_q.size());
    endtask

    // random well-formed header, lengths often placed around the limit
    task automatic random_header(input logic [31:0] lim);
        int                   pick;
        wsfhp_pkg::len_form_t form;
        logic [31:0]          len;
        logic [31:0]          around;
        pick   = $urandom_range(0, 3);
        form   = (pick < 2) ? wsfhp_pkg::LEN_SHORT :
                 ((pick == 2) ? wsfhp_pkg::LEN_EXT16 : wsfhp_pkg::LEN_EXT64);
        around = lim + 32'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 3) == 0)
            len = around;
        else
            len = $urandom;
        if (form == wsfhp_pkg::LEN_SHORT && len > 32'd125)
            len = $urandom_range(0, 125);
        else if (form == wsfhp_pkg::LEN_EXT16 && len > 32'hffff)
            len = $urandom_range(0, 65535);
        build_header(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len,
                     $urandom, $urandom);
    endtask

    // wait until every predicted header has come out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output side backpressure in random bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            if (quiet || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // main stimulus
    initial
    begin
        logic [31:0] limits[PHASES];
        logic [31:0] cur_limit;
        int          target;
        int          kind;
        int          n_stray;
        logic [7:0]  sb;
        logic        sf;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flag extremes, short length zero and 125, masked 16-bit max,
        // byte while idle, restart mid-header, 64-bit form with upper bytes lost
        build_header(8'hff, 1'b0, wsfhp_pkg::LEN_SHORT, 32'd0, 32'd0, 32'd0);
        send_header(hdr_q.size());
        build_header(8'h00, 1'b0, wsfhp_pkg::LEN_SHORT, 32'd125, 32'd0, 32'd0);
        send_header(hdr_q.size());
        build_header(8'h81, 1'b1, wsfhp_pkg::LEN_EXT16, 32'hffff, 32'd0, 32'hdead_beef);
        send_header(hdr_q.size());
        push_byte(8'haa, 1'b0);
        build_header(8'h82, 1'b0, wsfhp_pkg::LEN_EXT64, 32'h10, 32'd0, 32'd0);
        send_header(2);
        build_header(8'h0a, 1'b1, wsfhp_pkg::LEN_EXT64, 32'hffff_ffff, 32'h1234_5678,
                     32'h0102_0304);
        send_header(hdr_q.size());
        wait_idle();

        // limit settings per phase; the first phase keeps the reset value
        limits[0] = wsfhp_pkg::MAX_LEN_RESET;
        limits[1] = 32'h0;
        limits[2] = 32'hffff_ffff;
        limits[3] = 32'd125;
        limits[4] = 32'hffff;
        limits[5] = $urandom;
        limits[6] = wsfhp_pkg::MAX_LEN_RESET;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            cur_limit = limits[ph];
            if (ph > 0)
                write_limit(cur_limit);
            quiet  = (ph == PHASES - 1);
            target = sent_cnt + BYTES_PER_PHASE;
            while (sent_cnt < target)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 8)
                begin
                    random_header(cur_limit);
                    send_header(hdr_q.size());
                end
                else if (kind == 8)
                begin
                    // header cut short, the next first byte restarts it
                    random_header(cur_limit);
                    send_header($urandom_range(1, hdr_q.size() - 1));
                end
                else
                begin
                    // loose bytes with random first flag
                    n_stray = $urandom_range(1, 3);
                    for (int i = 0; i < n_stray; i++)
                    begin
                        sb = 8'($urandom_range(0, 255));
                        sf = ($urandom_range(0, 3) == 0);
                        push_byte(sb, sf);
                        if (sf || open_hdr)
                            sent_cnt++;
                        if (sf)
                            open_hdr = 1'b1;
                    end
                end
            end
            wait_idle();
        end

        // drain and verdict
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (n_fail == 0 && n_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/wsfhp_pkg.sv
hdl/wsfhp_parser.sv
hdl/websocket_frame_header_parser_core.sv
dv/wsfhp_header_checker.sv
dv/tb_websocket_frame_header_parser_core.sv
